// ===== rtl/cartridge_bank_controller_assert.svh =====
// Assertion macros for the cartridge bank controller.
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Implication or plain property, checked on clk_i outside reset.
`define CBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define CBC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define CBC_ASSERT(lbl, prop, msg)
`define CBC_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/cbc_pkg.sv =====
// Shared types, constants and decode helpers for the cartridge bank controller.
`timescale 1ns / 1ps

package cbc_pkg;

  localparam int RAM_DEPTH     = 32768;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int ROM_ADDR_BITS = 21;
  localparam int ROM_AW        = 21;  // fixed width of the rom_address field
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE    = 2'd2;

  localparam logic [4:0] ROM_SIZE_RESET = 5'd15;
  localparam logic [4:0] ROM_SIZE_MIN   = 5'd15;
  localparam logic [4:0] ROM_SIZE_MAX   = 5'(ROM_ADDR_BITS);
  localparam logic [3:0] RAM_SIZE_RESET = 4'd13;
  localparam logic [3:0] RAM_SIZE_MIN   = 4'd11;
  localparam logic [3:0] RAM_SIZE_MAX   = 4'd15;

  localparam logic [3:0] RAM_GATE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS     = 8'hFF;

  localparam logic [0:0] MODE_READ  = 1'b0;
  localparam logic [0:0] MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    RG_GATE,
    RG_BANK,
    RG_UPPER,
    RG_MODE,
    RG_RAM,
    RG_NONE
  } region_e;

  // Decode result handed from the mapper to the pipeline.
  typedef struct packed {
    logic              ram_we;
    logic              ram_rd;
    logic [RAM_AW-1:0] ram_idx;
    logic [7:0]        rdata;
    logic              fetch;
    logic [ROM_AW-1:0] raddr;
    logic              unm;
  } map_t;

  function automatic region_e region_of(logic [15:0] addr);
    region_e r;
    case (addr[15:13])
      3'b000:  r = RG_GATE;
      3'b001:  r = RG_BANK;
      3'b010:  r = RG_UPPER;
      3'b011:  r = RG_MODE;
      3'b101:  r = RG_RAM;
      default: r = RG_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cbc_ram.sv =====
// Cartridge RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module cbc_ram import cbc_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [RAM_AW-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [RAM_AW-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [RAM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cbc_map.sv =====
// Banking and configuration registers with the address mapper.
`timescale 1ns / 1ps

module cbc_map import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  acc_i,
  input  logic                  mode_i,
  input  logic [15:0]           bus_address_i,
  input  logic [7:0]            write_data_i,
  output map_t                  map_o
);

  logic [4:0] rom_size_q, rom_size_d;
  logic       ram_present_q, ram_present_d;
  logic [3:0] ram_size_q, ram_size_d;
  logic       ram_gate_q, ram_gate_d;
  logic [4:0] rom_bank_q, rom_bank_d;
  logic [1:0] upper_q, upper_d;
  logic       bmode_q, bmode_d;

  region_e           region;
  logic              wr;
  logic              ram_on;
  logic [4:0]        rom_n;
  logic [3:0]        ram_n;
  logic [ROM_AW-1:0] rom_mask;
  logic [14:0]       ram_mask;
  logic [14:0]       ram_lin;
  logic [4:0]        bank_eff;
  logic [ROM_AW-1:0] rom_lin;

  assign region = region_of(bus_address_i);
  assign wr     = (mode_i == MODE_WRITE);
  assign ram_on = ram_gate_q & ram_present_q;

  always_comb begin
    rom_size_d    = rom_size_q;
    ram_present_d = ram_present_q;
    ram_size_d    = ram_size_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROM_SIZE:    rom_size_d    = cfg_data_i;
        CFG_RAM_PRESENT: ram_present_d = cfg_data_i[0];
        CFG_RAM_SIZE:    ram_size_d    = cfg_data_i[3:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    ram_gate_d = ram_gate_q;
    rom_bank_d = rom_bank_q;
    upper_d    = upper_q;
    bmode_d    = bmode_q;
    if (acc_i && wr) begin
      case (region)
        RG_GATE:  ram_gate_d = (write_data_i[3:0] == RAM_GATE_KEY);
        RG_BANK:  rom_bank_d = write_data_i[4:0];
        RG_UPPER: upper_d    = write_data_i[1:0];
        RG_MODE:  bmode_d    = write_data_i[0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q    <= ROM_SIZE_RESET;
      ram_present_q <= 1'b0;
      ram_size_q    <= RAM_SIZE_RESET;
      ram_gate_q    <= 1'b0;
      rom_bank_q    <= '0;
      upper_q       <= '0;
      bmode_q       <= 1'b0;
    end else begin
      rom_size_q    <= rom_size_d;
      ram_present_q <= ram_present_d;
      ram_size_q    <= ram_size_d;
      ram_gate_q    <= ram_gate_d;
      rom_bank_q    <= rom_bank_d;
      upper_q       <= upper_d;
      bmode_q       <= bmode_d;
    end
  end

  // Clamp sizes to the supported range.
  always_comb begin
    rom_n = rom_size_q;
    if (rom_n < ROM_SIZE_MIN) rom_n = ROM_SIZE_MIN;
    if (rom_n > ROM_SIZE_MAX) rom_n = ROM_SIZE_MAX;
    ram_n = ram_size_q;
    if (ram_n < RAM_SIZE_MIN) ram_n = RAM_SIZE_MIN;
  end

  assign rom_mask = ROM_AW'((33'd1 << rom_n) - 33'd1);
  assign ram_mask = 15'((17'd1 << ram_n) - 17'd1);
  assign bank_eff = (rom_bank_q == 5'd0) ? 5'd1 : rom_bank_q;

  always_comb begin
    if (!bus_address_i[14]) begin
      rom_lin = {bmode_q ? upper_q : 2'b00, 5'd0, bus_address_i[13:0]};
    end else begin
      rom_lin = {upper_q, bank_eff, bus_address_i[13:0]};
    end
  end

  assign ram_lin = {bmode_q ? upper_q : 2'b00, bus_address_i[12:0]} & ram_mask;

  always_comb begin
    map_o         = '0;
    map_o.ram_idx = ram_lin[RAM_AW-1:0];
    case (region)
      RG_GATE, RG_BANK, RG_UPPER, RG_MODE: begin
        if (!wr) begin
          map_o.fetch = 1'b1;
          map_o.raddr = rom_lin & rom_mask;
        end
      end
      RG_RAM: begin
        map_o.ram_we = acc_i & wr & ram_on;
        map_o.ram_rd = acc_i & !wr & ram_on;
        if (!wr && !ram_on) map_o.rdata = OPEN_BUS;
      end
      default: begin
        map_o.unm = 1'b1;
        if (!wr) map_o.rdata = OPEN_BUS;
      end
    endcase
  end

endmodule

// ===== rtl/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: mapper, cartridge RAM, result pipeline.
//
//  channel  direction  handshake                 payload
//  in       to block   in_valid_i / in_stall_o   mode_i, bus_address_i, write_data_i
//  out      from block out_valid_o / out_stall_i read_data_o, rom_fetch_o,
//                                                rom_address_o, unmapped_o
//  cfg      to block   cfg_we_i (no handshake)   cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while the input is not stalled. A result
// passes through the RAM stage register and then the output register, set by
// the registered read of the cartridge RAM.
// Banking registers update at the accepting edge, so the next access sees them.
// A RAM write lands in the array before any later read can sample it.
// Input stalls only when both the RAM stage and the output register are full
// and the output is stalled. No clearing pass: RAM content is undefined.
`timescale 1ns / 1ps

`include "cartridge_bank_controller_assert.svh"

module cartridge_bank_controller import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [15:0]           bus_address_i,
  input  logic [7:0]            write_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            read_data_o,
  output logic                  rom_fetch_o,
  output logic [ROM_AW-1:0]     rom_address_o,
  output logic                  unmapped_o
);

  logic       in_acc;
  logic       s1_adv;
  logic       out_free;
  map_t       map;
  logic [7:0] ram_rdata;

  // RAM stage: the item whose RAM read is in flight
  logic              s1_valid_q, s1_valid_d;
  logic              s1_ram_rd_q;
  logic [7:0]        s1_rdata_q;
  logic              s1_fetch_q;
  logic [ROM_AW-1:0] s1_raddr_q;
  logic              s1_unm_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_rdata_q;
  logic              out_fetch_q;
  logic [ROM_AW-1:0] out_raddr_q;
  logic              out_unm_q;

  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & !in_stall_o;
  assign out_free   = !out_valid_q | !out_stall_i;
  assign s1_adv     = s1_valid_q & out_free;

  cbc_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .acc_i         (in_acc),
    .mode_i        (mode_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .map_o         (map)
  );

  cbc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (map.ram_we),
    .waddr_i (map.ram_idx),
    .wdata_i (write_data_i),
    .re_i    (map.ram_rd),
    .raddr_i (map.ram_idx),
    .rdata_o (ram_rdata)
  );

  assign s1_valid_d  = in_acc | (s1_valid_q & !s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ram_rd_q <= map.ram_rd;
      s1_rdata_q  <= map.rdata;
      s1_fetch_q  <= map.fetch;
      s1_raddr_q  <= map.raddr;
      s1_unm_q    <= map.unm;
    end
  end

  // RAM data is held by the RAM until the next read, so a waiting item keeps it.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rdata_q <= s1_ram_rd_q ? ram_rdata : s1_rdata_q;
      out_fetch_q <= s1_fetch_q;
      out_raddr_q <= s1_raddr_q;
      out_unm_q   <= s1_unm_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rdata_q;
  assign rom_fetch_o   = out_fetch_q;
  assign rom_address_o = out_raddr_q;
  assign unmapped_o    = out_unm_q;

  `CBC_NEVER(a_ram_rw_excl, map.ram_we && map.ram_rd, "RAM read and write together")
  `CBC_ASSERT(a_fetch_clean, out_valid_o && rom_fetch_o |-> !unmapped_o && read_data_o == 8'd0, "bad fetch")
  `CBC_ASSERT(a_s1_drains, s1_valid_q && !out_stall_i |=> out_valid_o, "RAM stage stuck")
  `CBC_NEVER(a_ram_acc_idle, (map.ram_we || map.ram_rd) && !in_acc, "RAM access while idle")

endmodule

// ===== tb/cartridge_bank_controller_tb.sv =====
// Self-checking testbench for the cartridge bank controller: bus accesses against a banking model.
`timescale 1ns / 1ps

import cbc_pkg::*;

// Address map boundaries of the cartridge bus
localparam logic [15:0] GATE_END  = 16'h2000;
localparam logic [15:0] BANK_END  = 16'h4000;
localparam logic [15:0] UPPER_END = 16'h6000;
localparam logic [15:0] ROM_END   = 16'h8000;
localparam logic [15:0] RAM_BASE  = 16'hA000;
localparam logic [15:0] RAM_END   = 16'hC000;

// One result transaction as the block should present it
typedef struct {
  logic [7:0]        read_data;
  logic              rom_fetch;
  logic [ROM_AW-1:0] phys_addr;
  logic              unmapped;
} bus_result_t;

class bus_access_scoreboard;
  // configuration copy
  logic [4:0] rom_log2;
  logic       ram_present;
  logic [3:0] ram_log2;
  // banking registers
  logic       gate;
  logic [4:0] bank_low;
  logic [1:0] upper;
  logic       bank_mode;
  // cartridge RAM image and which cells hold a known byte
  logic [7:0] ram_image [RAM_DEPTH];
  bit         ram_written [RAM_DEPTH];
  bus_result_t pending_results [$];
  int errors, results_seen;
  int rom_reads, ram_hits, open_bus_reads, ram_stores, reg_writes, unmapped_hits;

  function new();
    rom_log2    = ROM_SIZE_RESET;
    ram_present = 1'b0;
    ram_log2    = RAM_SIZE_RESET;
    gate        = 1'b0;
    bank_low    = '0;
    upper       = '0;
    bank_mode   = 1'b0;
    foreach (ram_written[i]) ram_written[i] = 1'b0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ROM_SIZE:    rom_log2 = val;
      CFG_RAM_PRESENT: ram_present = val[0];
      CFG_RAM_SIZE:    ram_log2 = val[3:0];
      default: ;
    endcase
  endfunction

  function int unsigned rom_wrap(int unsigned a);
    int unsigned n;
    n = 32'(rom_log2);
    if (n < 15) n = 15;
    if (n > ROM_ADDR_BITS) n = ROM_ADDR_BITS;
    return a & ((32'd1 << n) - 1);
  endfunction

  function int unsigned ram_slot(logic [15:0] a);
    int unsigned n, s;
    s = 32'(a[12:0]);
    n = 32'(ram_log2);
    if (n < 11) n = 11;
    if (n > 15) n = 15;
    if (bank_mode) s = s | (int'(upper) << 13);
    s = s & ((32'd1 << n) - 1);
    return s % RAM_DEPTH;
  endfunction

  function bit ram_enabled();
    return gate && ram_present;
  endfunction

  // True when a read would hit a RAM cell that has never been written
  function bit unwritten_read(logic m, logic [15:0] a);
    return m == MODE_READ && a >= RAM_BASE && a < RAM_END && ram_enabled()
           && !ram_written[ram_slot(a)];
  endfunction

  // Work out the result of one accepted access and update the banking state
  function void predict_access(logic m, logic [15:0] a, logic [7:0] d);
    bus_result_t r;
    int unsigned phys, bank;
    r.read_data   = 8'h00;
    r.rom_fetch   = 1'b0;
    r.phys_addr   = '0;
    r.unmapped    = 1'b0;
    if (a < ROM_END) begin
      if (m == MODE_WRITE) begin
        reg_writes++;
        if (a < GATE_END) gate = (d[3:0] == RAM_GATE_KEY);
        else if (a < BANK_END) bank_low = d[4:0];
        else if (a < UPPER_END) upper = d[1:0];
        else bank_mode = d[0];
      end else begin
        rom_reads++;
        if (a < BANK_END) begin
          phys = 32'(a);
          if (bank_mode) phys = phys | (int'(upper) << 19);
        end else begin
          bank = (bank_low == 0) ? 1 : 32'(bank_low);
          phys = (int'(upper) << 19) | (bank << 14) | 32'(a[13:0]);
        end
        r.rom_fetch   = 1'b1;
        r.phys_addr   = ROM_AW'(rom_wrap(phys));
      end
    end else if (a >= RAM_BASE && a < RAM_END) begin
      if (m == MODE_WRITE) begin
        if (ram_enabled()) begin
          ram_image[ram_slot(a)]   = d;
          ram_written[ram_slot(a)] = 1'b1;
          ram_stores++;
        end
      end else if (ram_enabled()) begin
        r.read_data = ram_image[ram_slot(a)];
        ram_hits++;
      end else begin
        r.read_data = OPEN_BUS;
        open_bus_reads++;
      end
    end else begin
      r.unmapped = 1'b1;
      if (m == MODE_READ) r.read_data = OPEN_BUS;
      unmapped_hits++;
    end
    pending_results.push_back(r);
  endfunction

  task report(string what, logic [31:0] want, logic [31:0] got);
    if (errors < 100)
      $display("mismatch at result %0d, %s: expected 0x%0h got 0x%0h",
               results_seen, what, want, got);
    errors++;
  endtask

  task check_result(logic [7:0] rd, logic fetch, logic [ROM_AW-1:0] raddr, logic unm);
    bus_result_t e;
    if (pending_results.size() == 0) begin
      report("unexpected result transaction", 0, 1);
    end else begin
      e = pending_results.pop_front();
      if (rd !== e.read_data) report("read_data", 32'(e.read_data), 32'(rd));
      if (fetch !== e.rom_fetch) report("rom_fetch", 32'(e.rom_fetch), 32'(fetch));
      if (raddr !== e.phys_addr) report("fetch address", 32'(e.phys_addr), 32'(raddr));
      if (unm !== e.unmapped) report("unmapped", 32'(e.unmapped), 32'(unm));
    end
    results_seen++;
  endtask

  function int pending();
    return pending_results.size();
  endfunction
endclass

module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES          = 8;
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES    = 6;    // pipeline is two deep
  localparam int IDLE_LIMIT      = 3000; // cycles without any transaction

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  mode_i;
  logic [15:0]           bus_address_i;
  logic [7:0]            write_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            read_data_o;
  logic                  rom_fetch_o;
  logic [ROM_AW-1:0]     rom_address_o;
  logic                  unmapped_o;

  bus_access_scoreboard sb = new();

  bit          hold_req;        // asks the receiver for one long hold-off
  int          idle_cycles;
  int          accesses_sent;
  int          settings_applied;
  logic [15:0] recent_ram [$];  // recently written RAM bus addresses, reused by reads

  cartridge_bank_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .rom_fetch_o   (rom_fetch_o),
    .rom_address_o (rom_address_o),
    .unmapped_o    (unmapped_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result side: every accepted result transaction is checked against the oldest
  // prediction. Outputs are sampled at the edge, before any update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(read_data_o, rom_fetch_o, rom_address_o, unmapped_o);
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: the stall pattern changes over the run, including stretches with no
  // stall at all; now and then a run of stall cycles; one long hold-off on request.
  initial begin : receiver
    int stall_pct, stall_run, tick;
    stall_pct = 0;
    stall_run = 0;
    tick = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 128 == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 35;
          default: stall_pct = 70;
        endcase
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall_i <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < 2) begin
        stall_run = $urandom_range(30, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Sender gap: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Offer one access after an optional gap and wait for it to be accepted.
  // A read that would land on a never-written RAM cell is turned into a write.
  task automatic send_access(logic m, logic [15:0] a, logic [7:0] d, int gap);
    logic m_eff;
    m_eff = sb.unwritten_read(m, a) ? MODE_WRITE : m;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m_eff;
    bus_address_i <= a;
    write_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_access(m_eff, a, d);
    accesses_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three size/presence registers, one per cycle; block must be idle.
  task automatic apply_setting(logic [4:0] rom, logic present, logic [4:0] ram);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROM_SIZE;
    cfg_data_i  <= rom;
    @(posedge clk_i);
    sb.set_register(CFG_ROM_SIZE, rom);
    cfg_index_i <= CFG_RAM_PRESENT;
    cfg_data_i  <= {4'b0, present};
    @(posedge clk_i);
    sb.set_register(CFG_RAM_PRESENT, {4'b0, present});
    cfg_index_i <= CFG_RAM_SIZE;
    cfg_data_i  <= ram;
    @(posedge clk_i);
    sb.set_register(CFG_RAM_SIZE, ram);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Settings cover both size extremes, out-of-range values that clamp, and RAM absent.
  task automatic apply_phase(int p);
    case (p)
      0: apply_setting(5'd21, 1'b1, 5'd15);
      1: apply_setting(5'd15, 1'b1, 5'd11);
      2: apply_setting(5'd18, 1'b1, 5'd13);
      3: apply_setting(5'd0,  1'b1, 5'd3);
      4: apply_setting(5'd31, 1'b0, 5'd31);
      5: apply_setting(5'd19, 1'b1, 5'd31);
      6: apply_setting(5'd17, 1'b1, 5'd12);
      default: apply_setting(5'd20, 1'b1, 5'd14);
    endcase
  endtask

  // Random access mix: ROM reads, banking writes (gate key favored), RAM traffic
  // that reuses written addresses, unmapped noise and window edges.
  task automatic gen_access(output logic m, output logic [15:0] a, output logic [7:0] d);
    int k;
    logic [1:0] reg_sel;
    logic [15:0] edges [10];
    edges = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'hA000,
              16'hBFFF, 16'h8000, 16'h9FFF, 16'hC000, 16'hFFFF};
    k = $urandom_range(99);
    d = 8'($urandom);
    if (k < 22) begin
      m = MODE_READ;
      a = 16'($urandom_range(16'h7FFF));
    end else if (k < 40) begin
      m = MODE_WRITE;
      reg_sel = 2'($urandom);
      a = {1'b0, reg_sel, 13'($urandom)};
      if (reg_sel == 2'd0 && $urandom_range(3) != 0) d = {d[7:4], RAM_GATE_KEY};
    end else if (k < 62) begin
      m = MODE_WRITE;
      a = {3'b101, 13'($urandom)};
      recent_ram.push_back(a);
      if (recent_ram.size() > 32) void'(recent_ram.pop_front());
    end else if (k < 88) begin
      m = MODE_READ;
      if (recent_ram.size() != 0 && $urandom_range(99) < 80)
        a = recent_ram[$urandom_range(recent_ram.size() - 1)];
      else
        a = {3'b101, 13'($urandom)};
    end else if (k < 96) begin
      m = 1'($urandom);
      a = $urandom_range(1) ? {3'b100, 13'($urandom)} : {2'b11, 14'($urandom)};
    end else begin
      m = 1'($urandom);
      a = edges[$urandom_range(9)];
    end
  endtask

  // Directed: window extremes, bank 0 read as bank 1, upper bank in mode 1 for both
  // ROM windows, gate key with and without upper nibble, RAM absent, unmapped edges.
  task automatic directed_banking();
    send_access(MODE_READ,  16'h0000, 8'hFF, 0);
    send_access(MODE_READ,  16'h3FFF, 8'h00, 0);
    send_access(MODE_READ,  16'h4000, 8'h00, 0);
    send_access(MODE_READ,  16'h7FFF, 8'h00, 0);
    send_access(MODE_WRITE, 16'h2000, 8'h00, 0);
    send_access(MODE_READ,  16'h5555, 8'h00, 0);
    send_access(MODE_WRITE, 16'h3FFF, 8'hFF, 0);
    send_access(MODE_READ,  16'h7FFF, 8'h00, 0);
    send_access(MODE_WRITE, 16'h4000, 8'hFF, 0);
    send_access(MODE_WRITE, 16'h6000, 8'h01, 0);
    send_access(MODE_READ,  16'h0000, 8'h00, 0);
    send_access(MODE_READ,  16'h4000, 8'h00, 0);
    send_access(MODE_READ,  16'hA000, 8'h00, 0);
    send_access(MODE_WRITE, 16'h0000, 8'h0A, 0);
    send_access(MODE_WRITE, 16'hA000, 8'h5A, 0);  // RAM absent: dropped
    send_access(MODE_READ,  16'hA000, 8'h00, 0);
    send_access(MODE_READ,  16'h8000, 8'h00, 0);
    send_access(MODE_WRITE, 16'h9FFF, 8'hFF, 0);
    send_access(MODE_READ,  16'hFFFF, 8'hFF, 0);
    send_access(MODE_WRITE, 16'hC000, 8'hFF, 0);
    send_access(MODE_WRITE, 16'h1FFF, 8'h1A, 0);
    send_access(MODE_WRITE, 16'h0000, 8'h0B, 0);
    send_access(MODE_WRITE, 16'h7FFF, 8'hFE, 0);
  endtask

  // Directed RAM: gate on, both window ends, upper bank in RAM mode, gate off.
  task automatic directed_ram();
    send_access(MODE_WRITE, 16'h0000, 8'h3A, 0);
    send_access(MODE_WRITE, 16'hA000, 8'h00, 0);
    send_access(MODE_WRITE, 16'hBFFF, 8'hFF, 0);
    send_access(MODE_READ,  16'hA000, 8'h00, 0);
    send_access(MODE_READ,  16'hBFFF, 8'h00, 0);
    send_access(MODE_WRITE, 16'h6000, 8'h01, 0);
    send_access(MODE_WRITE, 16'hA123, 8'h77, 0);
    send_access(MODE_READ,  16'hA123, 8'h00, 0);
    send_access(MODE_WRITE, 16'h4000, 8'h00, 0);
    send_access(MODE_READ,  16'hA000, 8'h00, 0);
    send_access(MODE_WRITE, 16'h0000, 8'h00, 0);
    send_access(MODE_READ,  16'hBFFF, 8'h00, 0);
    send_access(MODE_WRITE, 16'h6000, 8'h00, 0);
  endtask

  initial begin : stimulus
    logic        m;
    logic [15:0] a;
    logic [7:0]  d;
    bit          quiet;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_ROM_SIZE;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    mode_i        <= MODE_READ;
    bus_address_i <= '0;
    write_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration first: smallest ROM, no RAM
    directed_banking();
    wait_idle();
    apply_phase(0);
    directed_ram();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        apply_phase(p);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long receiver hold-off while the sender keeps offering back to back
        if (p == 2 && i == 40) hold_req = 1'b1;
        // sender pause until the pipeline is empty
        if (p == 5 && i == 75) wait_idle();
        quiet = (p == 2 && i >= 40 && i < 100) || ((i / 40) % 4 == 1);
        gen_access(m, a, d);
        send_access(m, a, d, quiet ? 0 : pick_gap());
      end
    end

    wait_idle();
    while (sb.pending() != 0) begin
      void'(sb.pending_results.pop_front());
      sb.report("result never arrived", 1, 0);
    end

    $display("covered %0d accesses over %0d size settings: %0d ROM fetches, %0d banking writes",
             accesses_sent, settings_applied, sb.rom_reads, sb.reg_writes);
    $display("RAM: %0d stores, %0d reads of stored bytes, %0d open-bus reads; %0d unmapped",
             sb.ram_stores, sb.ram_hits, sb.open_bus_reads, sb.unmapped_hits);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
